@@ hdl/distributed_mutex_ticket_node_defines.svh @@
// assertion macros shared by the ticket node rtl
// no dependencies; included by modules that carry assertions
`ifndef DISTRIBUTED_MUTEX_TICKET_NODE_DEFINES_SVH
`define DISTRIBUTED_MUTEX_TICKET_NODE_DEFINES_SVH

`ifndef SYNTHESIS
`define DMTN_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dmtn assertion failed");
`define DMTN_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dmtn forbidden condition");
`else
`define DMTN_ASSERT(label, clk, rst_n, prop)
`define DMTN_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

@@ hdl/dmtn_pkg.sv @@
// shared types, codes and constants of the ticket node
// no dependencies
package dmtn_pkg;

    localparam int TICKET_BITS     = 16;
    localparam int MAX_PENDING_DEF = 16;

    typedef logic [TICKET_BITS-1:0] t_ticket;

    localparam t_ticket TICKET_MAX = {TICKET_BITS{1'b1}};

    typedef enum logic [1:0] {
        CMD_WANT  = 2'd0,
        CMD_REQ   = 2'd1,
        CMD_OK    = 2'd2,
        CMD_LEAVE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_BCAST = 2'd0,
        KIND_GRANT = 2'd1,
        KIND_ENTER = 2'd2
    } t_kind;

    localparam logic [1:0] REG_NODE  = 2'd0;
    localparam logic [1:0] REG_PROC  = 2'd1;
    localparam logic [1:0] REG_TYPE  = 2'd2;
    localparam logic [1:0] REG_OKS   = 2'd3;

    typedef struct packed {
        logic [3:0] node;
        logic [3:0] proc;
        logic [2:0] ptype;
        logic [7:0] oks;
    } t_cfg;

    typedef struct packed {
        logic acc;
        logic sweep_rd;
        logic sweep_last;
    } t_dp_ctl;

endpackage

@@ hdl/distributed_mutex_ticket_node.sv @@
// ticket node: a want, request or ok is decided on acceptance; its result, if any,
// strobes for one cycle on the cycle after the accept and busy stays low
// a leave with n deferred grants holds busy while the grant store is
// read one entry a cycle; the grants then strobe on consecutive cycles once the sweep
// state is entered and each store read is registered, the last one marked
// reset is synchronous and clears control state and registers; the grant store is not cleared
module distributed_mutex_ticket_node #(
    parameter int MAX_PENDING = dmtn_pkg::MAX_PENDING_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_cmd,
    input  dmtn_pkg::t_ticket i_req_ticket,
    input  logic [2:0]        i_req_type,
    input  logic [3:0]        i_req_node,
    input  logic [3:0]        i_req_process,
    output logic              o_strobe,
    output logic [1:0]        o_kind,
    output dmtn_pkg::t_ticket o_ticket_out,
    output logic [3:0]        o_dest_node,
    output logic [3:0]        o_dest_process,
    output logic              o_last
);
    import dmtn_pkg::*;

    localparam int PCW = $clog2(MAX_PENDING + 1);
    localparam int IW  = $clog2(MAX_PENDING);

    t_cfg           w_cfg;
    t_dp_ctl        w_ctl;
    logic [PCW-1:0] w_pend_cnt;
    logic [IW-1:0]  w_rd_idx;

    dmtn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dmtn_ctrl #(
        .MAX_PENDING (MAX_PENDING)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd      (i_cmd),
        .i_pend_cnt (w_pend_cnt),
        .busy       (busy),
        .o_ctl      (w_ctl),
        .o_rd_idx   (w_rd_idx)
    );

    dmtn_dp #(
        .MAX_PENDING (MAX_PENDING)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_cfg          (w_cfg),
        .i_rd_idx       (w_rd_idx),
        .i_cmd          (i_cmd),
        .i_req_ticket   (i_req_ticket),
        .i_req_type     (i_req_type),
        .i_req_node     (i_req_node),
        .i_req_process  (i_req_process),
        .o_pend_cnt     (w_pend_cnt),
        .o_strobe       (o_strobe),
        .o_kind         (o_kind),
        .o_ticket_out   (o_ticket_out),
        .o_dest_node    (o_dest_node),
        .o_dest_process (o_dest_process),
        .o_last         (o_last)
    );

endmodule

@@ hdl/dmtn_cfg.sv @@
// apb configuration registers of the ticket node
// depends on dmtn_pkg
module dmtn_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output dmtn_pkg::t_cfg o_cfg
);
    import dmtn_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node  <= 4'd0;
            r_cfg.proc  <= 4'd0;
            r_cfg.ptype <= 3'd0;
            r_cfg.oks   <= 8'd1;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_NODE: r_cfg.node  <= pwdata[3:0];
                REG_PROC: r_cfg.proc  <= pwdata[3:0];
                REG_TYPE: r_cfg.ptype <= pwdata[2:0];
                REG_OKS:  r_cfg.oks   <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_NODE: prdata = {28'd0, r_cfg.node};
            REG_PROC: prdata = {28'd0, r_cfg.proc};
            REG_TYPE: prdata = {29'd0, r_cfg.ptype};
            REG_OKS:  prdata = {24'd0, r_cfg.oks};
        endcase
    end

endmodule

@@ hdl/dmtn_ctrl.sv @@
// controller: accepts commands and sequences the release sweep on leave
// depends on dmtn_pkg and the defines header
`include "distributed_mutex_ticket_node_defines.svh"
module dmtn_ctrl #(
    parameter int MAX_PENDING = dmtn_pkg::MAX_PENDING_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic [1:0]                         i_cmd,
    input  logic [$clog2(MAX_PENDING+1)-1:0]   i_pend_cnt,
    output logic                               busy,
    output dmtn_pkg::t_dp_ctl                  o_ctl,
    output logic [$clog2(MAX_PENDING)-1:0]     o_rd_idx
);
    import dmtn_pkg::*;

    localparam int PCW = $clog2(MAX_PENDING + 1);
    localparam int IW  = $clog2(MAX_PENDING);

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    t_state         r_state;
    logic [IW-1:0]  r_idx;
    logic [PCW-1:0] r_cnt;
    logic           w_last;

    assign w_last = (PCW'(r_idx) + PCW'(1)) == r_cnt;

    assign busy             = (r_state == ST_SWEEP);
    assign o_ctl.acc        = start && (r_state == ST_IDLE);
    assign o_ctl.sweep_rd   = (r_state == ST_SWEEP);
    assign o_ctl.sweep_last = w_last;
    assign o_rd_idx         = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_ctl.acc && (t_cmd'(i_cmd) == CMD_LEAVE) && (i_pend_cnt != '0)) begin
                        r_state <= ST_SWEEP;
                        r_idx   <= '0;
                        r_cnt   <= i_pend_cnt;
                    end
                end
                ST_SWEEP: begin
                    if (w_last) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
            endcase
        end
    end

    `DMTN_ASSERT(a_idx_in_range, i_clk, i_rst_n, (r_state == ST_SWEEP) |-> (PCW'(r_idx) < r_cnt))
    `DMTN_ASSERT(a_sweep_ends, i_clk, i_rst_n, ((r_state == ST_SWEEP) && w_last) |=> (r_state == ST_IDLE))
    `DMTN_ASSERT(a_leave_sweeps, i_clk, i_rst_n, (o_ctl.acc && (i_cmd == CMD_LEAVE) && (i_pend_cnt != '0)) |=> busy)

endmodule

@@ hdl/dmtn_dp.sv @@
// datapath: tickets, priority compare, ok counter, deferred grant store, result registers
// depends on dmtn_pkg and the defines header
`include "distributed_mutex_ticket_node_defines.svh"
module dmtn_dp #(
    parameter int MAX_PENDING = dmtn_pkg::MAX_PENDING_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dmtn_pkg::t_dp_ctl                  i_ctl,
    input  dmtn_pkg::t_cfg                     i_cfg,
    input  logic [$clog2(MAX_PENDING)-1:0]     i_rd_idx,
    input  logic [1:0]                         i_cmd,
    input  dmtn_pkg::t_ticket                  i_req_ticket,
    input  logic [2:0]                         i_req_type,
    input  logic [3:0]                         i_req_node,
    input  logic [3:0]                         i_req_process,
    output logic [$clog2(MAX_PENDING+1)-1:0]   o_pend_cnt,
    output logic                               o_strobe,
    output logic [1:0]                         o_kind,
    output dmtn_pkg::t_ticket                  o_ticket_out,
    output logic [3:0]                         o_dest_node,
    output logic [3:0]                         o_dest_process,
    output logic                               o_last
);
    import dmtn_pkg::*;

    localparam int PCW = $clog2(MAX_PENDING + 1);
    localparam int IW  = $clog2(MAX_PENDING);

    logic           r_wanting;
    t_ticket        r_my_ticket;
    t_ticket        r_max_seen;
    logic [7:0]     r_ok_count;
    logic [PCW-1:0] r_pend_cnt;
    logic [7:0]     r_mem [MAX_PENDING];
    logic [7:0]     r_rd_data;

    logic           r_res_vld;
    t_kind          r_res_kind;
    t_ticket        r_res_ticket;
    logic [3:0]     r_res_node;
    logic [3:0]     r_res_proc;
    logic           r_sweep_vld;
    logic           r_sweep_last;

    t_ticket    w_want_ticket;
    logic       w_grant;
    logic       w_has_room;
    logic       w_defer;
    logic [7:0] w_ok_inc;
    t_cmd       w_cmd;

    assign w_cmd         = t_cmd'(i_cmd);
    assign w_want_ticket = (r_max_seen >= TICKET_MAX) ? TICKET_MAX : r_max_seen + t_ticket'(1);
    assign w_ok_inc      = r_ok_count + 8'd1;
    assign w_has_room    = r_pend_cnt < PCW'(MAX_PENDING);

    // lower ticket, then higher type, then lower node, then lower process
    always_comb begin
        w_grant = !r_wanting || (i_req_ticket < r_my_ticket) ||
                  ((i_req_ticket == r_my_ticket) &&
                   ((i_req_type > i_cfg.ptype) ||
                    ((i_req_type == i_cfg.ptype) &&
                     ((i_req_node < i_cfg.node) ||
                      ((i_req_node == i_cfg.node) && (i_req_process < i_cfg.proc))))));
    end

    assign w_defer = i_ctl.acc && (w_cmd == CMD_REQ) && !w_grant && w_has_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanting   <= 1'b0;
            r_my_ticket <= '0;
            r_max_seen  <= '0;
            r_ok_count  <= 8'd0;
            r_pend_cnt  <= '0;
            r_res_vld   <= 1'b0;
            r_sweep_vld <= 1'b0;
        end else begin
            r_res_vld    <= 1'b0;
            r_sweep_vld  <= i_ctl.sweep_rd;
            r_sweep_last <= i_ctl.sweep_last;
            if (i_ctl.acc) begin
                unique case (w_cmd)
                    CMD_WANT: begin
                        r_wanting    <= 1'b1;
                        r_my_ticket  <= w_want_ticket;
                        r_res_vld    <= 1'b1;
                        r_res_kind   <= KIND_BCAST;
                        r_res_ticket <= w_want_ticket;
                        r_res_node   <= 4'd0;
                        r_res_proc   <= 4'd0;
                    end
                    CMD_REQ: begin
                        if (i_req_ticket > r_max_seen) begin
                            r_max_seen <= i_req_ticket;
                        end
                        if (w_grant) begin
                            r_res_vld    <= 1'b1;
                            r_res_kind   <= KIND_GRANT;
                            r_res_ticket <= '0;
                            r_res_node   <= i_req_node;
                            r_res_proc   <= i_req_process;
                        end else if (w_has_room) begin
                            r_pend_cnt <= r_pend_cnt + PCW'(1);
                        end
                    end
                    CMD_OK: begin
                        if (w_ok_inc == i_cfg.oks) begin
                            r_ok_count   <= 8'd0;
                            r_res_vld    <= 1'b1;
                            r_res_kind   <= KIND_ENTER;
                            r_res_ticket <= '0;
                            r_res_node   <= 4'd0;
                            r_res_proc   <= 4'd0;
                        end else begin
                            r_ok_count <= w_ok_inc;
                        end
                    end
                    CMD_LEAVE: begin
                        r_wanting  <= 1'b0;
                        r_pend_cnt <= '0;
                    end
                endcase
            end
        end
    end

    // deferred grant store, node in the upper nibble
    always_ff @(posedge i_clk) begin
        if (w_defer) begin
            r_mem[r_pend_cnt[IW-1:0]] <= {i_req_node, i_req_process};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sweep_rd) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_pend_cnt     = r_pend_cnt;
    assign o_strobe       = r_res_vld || r_sweep_vld;
    assign o_kind         = r_sweep_vld ? KIND_GRANT : r_res_kind;
    assign o_ticket_out   = r_sweep_vld ? '0 : r_res_ticket;
    assign o_dest_node    = r_sweep_vld ? r_rd_data[7:4] : r_res_node;
    assign o_dest_process = r_sweep_vld ? r_rd_data[3:0] : r_res_proc;
    assign o_last         = r_sweep_vld ? r_sweep_last : 1'b1;

    `DMTN_ASSERT(a_pend_bound, i_clk, i_rst_n, r_pend_cnt <= PCW'(MAX_PENDING))
    `DMTN_ASSERT_NEVER(a_one_source, i_clk, i_rst_n, r_res_vld && r_sweep_vld)
    `DMTN_ASSERT(a_res_follows_acc, i_clk, i_rst_n, r_res_vld |-> $past(i_ctl.acc))

endmodule

@@ test/distributed_mutex_ticket_node_tb.sv @@
// self-checking testbench for the ticket-based mutual exclusion node
// depends on dmtn_pkg and distributed_mutex_ticket_node; predicts every result beat
// from its own copy of the node state and compares field by field
module distributed_mutex_ticket_node_tb;
    import dmtn_pkg::*;

    typedef struct packed {
        t_kind      kind;
        t_ticket    ticket;
        logic [3:0] node;
        logic [3:0] proc;
        logic       last_beat;
    } t_mutex_msg;

    typedef struct packed {
        logic [3:0] node;
        logic [3:0] proc;
    } t_grant_dest;

    class mutex_msg_tracker;
        logic [3:0]  node_id;
        logic [3:0]  proc_id;
        logic [2:0]  prio_type;
        logic [7:0]  oks_to_enter;
        bit          wanting;
        bit          in_section;
        t_ticket     my_ticket;
        t_ticket     max_seen;
        logic [7:0]  ok_count;
        t_grant_dest deferred[$];
        t_mutex_msg  msgs_due[$];
        int          errors;
        int          beats_in;
        int          beats_out;
        int          enters;
        int          released;
        int          dropped;

        function new();
            node_id      = '0;
            proc_id      = '0;
            prio_type    = '0;
            oks_to_enter = 8'd1;
            wanting      = 1'b0;
            in_section   = 1'b0;
            my_ticket    = '0;
            max_seen     = '0;
            ok_count     = '0;
            errors       = 0;
            beats_in     = 0;
            beats_out    = 0;
            enters       = 0;
            released     = 0;
            dropped      = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_NODE: node_id = val[3:0];
                REG_PROC: proc_id = val[3:0];
                REG_TYPE: prio_type = val[2:0];
                REG_OKS:  oks_to_enter = val[7:0];
                default: ;
            endcase
        endfunction

        function void due(t_kind k, t_ticket tk, logic [3:0] nd, logic [3:0] pr, logic lst);
            t_mutex_msg m;
            m.kind      = k;
            m.ticket    = tk;
            m.node      = nd;
            m.proc      = pr;
            m.last_beat = lst;
            msgs_due.push_back(m);
        endfunction

        function void take_item(t_cmd c, t_ticket tk, logic [2:0] ty, logic [3:0] nd,
                                logic [3:0] pr);
            bit          grant;
            t_grant_dest d;
            beats_in++;
            case (c)
                CMD_WANT: begin
                    wanting   = 1'b1;
                    my_ticket = (max_seen == TICKET_MAX) ? TICKET_MAX : max_seen + 1'b1;
                    due(KIND_BCAST, my_ticket, 4'd0, 4'd0, 1'b1);
                end
                CMD_REQ: begin
                    if (tk > max_seen)
                        max_seen = tk;
                    // priority: lower ticket, higher type, lower node, lower process
                    grant = !wanting || tk < my_ticket ||
                            (tk == my_ticket && (ty > prio_type ||
                             (ty == prio_type && (nd < node_id ||
                              (nd == node_id && pr < proc_id)))));
                    if (grant) begin
                        due(KIND_GRANT, '0, nd, pr, 1'b1);
                    end else if (deferred.size() < MAX_PENDING_DEF) begin
                        d.node = nd;
                        d.proc = pr;
                        deferred.push_back(d);
                    end else begin
                        dropped++;
                    end
                end
                CMD_OK: begin
                    ok_count = ok_count + 8'd1;
                    if (ok_count == oks_to_enter) begin
                        ok_count   = '0;
                        in_section = 1'b1;
                        enters++;
                        due(KIND_ENTER, '0, 4'd0, 4'd0, 1'b1);
                    end
                end
                default: begin
                    wanting    = 1'b0;
                    in_section = 1'b0;
                    foreach (deferred[i])
                        due(KIND_GRANT, '0, deferred[i].node, deferred[i].proc,
                            i == deferred.size() - 1);
                    released += deferred.size();
                    deferred.delete();
                end
            endcase
        endfunction

        function void check_msg(t_mutex_msg got);
            t_mutex_msg exp_msg;
            beats_out++;
            if (msgs_due.size() == 0) begin
                $error("unexpected result beat: kind %0d ticket %0d node %0d process %0d",
                       got.kind, got.ticket, got.node, got.proc);
                errors++;
                return;
            end
            exp_msg = msgs_due.pop_front();
            if (got.kind !== exp_msg.kind) begin
                $error("kind: expected %0d, got %0d", exp_msg.kind, got.kind);
                errors++;
            end
            if (got.ticket !== exp_msg.ticket) begin
                $error("ticket_out: expected %0d, got %0d", exp_msg.ticket, got.ticket);
                errors++;
            end
            if (got.node !== exp_msg.node) begin
                $error("dest_node: expected %0d, got %0d", exp_msg.node, got.node);
                errors++;
            end
            if (got.proc !== exp_msg.proc) begin
                $error("dest_process: expected %0d, got %0d", exp_msg.proc, got.proc);
                errors++;
            end
            if (got.last_beat !== exp_msg.last_beat) begin
                $error("last: expected %0d, got %0d", exp_msg.last_beat, got.last_beat);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start         = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd         = '0;
    t_ticket     i_req_ticket  = '0;
    logic [2:0]  i_req_type    = '0;
    logic [3:0]  i_req_node    = '0;
    logic [3:0]  i_req_process = '0;
    logic        o_strobe;
    logic [1:0]  o_kind;
    t_ticket     o_ticket_out;
    logic [3:0]  o_dest_node;
    logic [3:0]  o_dest_process;
    logic        o_last;

    mutex_msg_tracker sb;
    bit               sender_gaps = 1'b1;

    distributed_mutex_ticket_node i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_req_ticket   (i_req_ticket),
        .i_req_type     (i_req_type),
        .i_req_node     (i_req_node),
        .i_req_process  (i_req_process),
        .o_strobe       (o_strobe),
        .o_kind         (o_kind),
        .o_ticket_out   (o_ticket_out),
        .o_dest_node    (o_dest_node),
        .o_dest_process (o_dest_process),
        .o_last         (o_last)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        t_mutex_msg got;
        if (i_rst_n && o_strobe) begin
            got.kind      = t_kind'(o_kind);
            got.ticket    = o_ticket_out;
            got.node      = o_dest_node;
            got.proc      = o_dest_process;
            got.last_beat = o_last;
            sb.check_msg(got);
        end
    end

    task automatic send_item(input t_cmd c, input t_ticket tk, input logic [2:0] ty,
                             input logic [3:0] nd, input logic [3:0] pr);
        i_cmd         <= c;
        i_req_ticket  <= tk;
        i_req_type    <= ty;
        i_req_node    <= nd;
        i_req_process <= pr;
        start         <= 1'b1;
        do @(posedge i_clk); while (busy);
        sb.take_item(c, tk, ty, nd, pr);
        if (sender_gaps && $urandom_range(0, 2) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // fields that the command ignores still get random values
    task automatic send_cmd(input t_cmd c);
        send_item(c, t_ticket'($urandom), 3'($urandom), 4'($urandom), 4'($urandom));
    endtask

    // request close to a ticket, biased toward ties with this node
    task automatic send_near_req(input int base);
        int         t;
        logic [2:0] ty;
        logic [3:0] nd;
        logic [3:0] pr;
        t = base + int'($urandom_range(0, 4)) - 2;
        if (t < 0)
            t = 0;
        if (t > 65535)
            t = 65535;
        ty = ($urandom_range(0, 1) == 0) ? sb.prio_type : 3'($urandom);
        nd = ($urandom_range(0, 1) == 0) ? sb.node_id : 4'($urandom);
        pr = ($urandom_range(0, 1) == 0) ? sb.proc_id : 4'($urandom);
        send_item(CMD_REQ, t_ticket'(t), ty, nd, pr);
    endtask

    function automatic int oks_until_enter();
        int n;
        n = (int'(sb.oks_to_enter) - int'(sb.ok_count) + 256) % 256;
        return (n == 0) ? 256 : n;
    endfunction

    // drain all expected beats and let the node go idle
    task automatic settle();
        start <= 1'b0;
        while (sb.msgs_due.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (4) @(posedge i_clk);
    endtask

    // one register write; the caller closes the transfer
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(input int nd, input int pr, input int ty, input int oks);
        settle();
        write_reg(REG_NODE, 32'(nd));
        write_reg(REG_PROC, 32'(pr));
        write_reg(REG_TYPE, 32'(ty));
        write_reg(REG_OKS, 32'(oks));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // want, a few requests and oks in random order, then leave
    task automatic run_round();
        int reqs;
        int oks;
        reqs = $urandom_range(0, 5);
        send_cmd(CMD_WANT);
        oks = oks_until_enter();
        if (oks > 8)
            oks = $urandom_range(1, 3);
        while (reqs + oks > 0) begin
            if (reqs > 0 && (oks == 0 || $urandom_range(0, 1) == 0)) begin
                send_near_req(int'(sb.my_ticket));
                reqs--;
            end else begin
                send_cmd(CMD_OK);
                oks--;
            end
        end
        send_cmd(CMD_LEAVE);
    endtask

    task automatic send_noise();
        t_cmd c;
        c = t_cmd'($urandom_range(0, 3));
        if (c == CMD_REQ)
            send_near_req(int'(sb.max_seen) + 1);
        else
            send_cmd(c);
    endtask

    initial begin
        int mark;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: node 0, process 0, type 0, one ok to enter
        send_item(CMD_OK, 16'd0, 3'd0, 4'd0, 4'd0);
        send_item(CMD_REQ, 16'd0, 3'd0, 4'd3, 4'd12);
        send_item(CMD_WANT, 16'hFFFF, 3'd7, 4'd15, 4'd15);
        send_item(CMD_REQ, 16'd0, 3'd0, 4'd1, 4'd2);
        send_item(CMD_REQ, 16'd1, 3'd0, 4'd0, 4'd0);
        send_item(CMD_REQ, 16'd2, 3'd5, 4'd6, 4'd7);
        send_item(CMD_WANT, 16'd0, 3'd0, 4'd0, 4'd0);
        send_item(CMD_REQ, 16'd3, 3'd7, 4'd15, 4'd15);
        send_item(CMD_OK, 16'hFFFF, 3'd7, 4'd15, 4'd15);
        send_item(CMD_LEAVE, 16'd0, 3'd0, 4'd0, 4'd0);
        send_item(CMD_LEAVE, 16'hFFFF, 3'd7, 4'd15, 4'd15);

        // tie-breaks against node 8, process 8, type 4
        configure(8, 8, 4, 2);
        send_item(CMD_WANT, 16'd0, 3'd0, 4'd0, 4'd0);
        send_item(CMD_REQ, 16'd4, 3'd4, 4'd7, 4'd15);
        send_item(CMD_REQ, 16'd4, 3'd4, 4'd8, 4'd7);
        send_item(CMD_REQ, 16'd4, 3'd4, 4'd8, 4'd9);
        send_item(CMD_REQ, 16'd4, 3'd3, 4'd0, 4'd0);
        send_item(CMD_REQ, 16'd4, 3'd4, 4'd9, 4'd0);
        send_item(CMD_REQ, 16'd5, 3'd7, 4'd0, 4'd0);
        send_item(CMD_OK, 16'd0, 3'd0, 4'd0, 4'd0);
        send_item(CMD_OK, 16'd0, 3'd0, 4'd0, 4'd0);
        send_item(CMD_LEAVE, 16'd0, 3'd0, 4'd0, 4'd0);

        for (int phase = 0; phase < 3; phase++) begin
            configure($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 7),
                      $urandom_range(1, 4));
            if (phase == 0) begin
                // overfill the grant store, then release a full sweep
                send_cmd(CMD_WANT);
                repeat (18)
                    send_item(CMD_REQ, sb.my_ticket + 1'b1, 3'($urandom), 4'($urandom),
                              4'($urandom));
                send_cmd(CMD_LEAVE);
            end
            mark = sb.beats_in;
            while (sb.beats_in - mark < 25) begin
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) send_noise();
                else
                    run_round();
            end
        end

        // largest identity and ok threshold
        configure(15, 15, 7, 255);
        send_cmd(CMD_WANT);
        repeat (4) send_near_req(int'(sb.my_ticket));
        repeat (3) send_cmd(CMD_OK);
        send_cmd(CMD_LEAVE);

        configure(0, 0, 0, 1);
        sender_gaps = 1'b0;
        send_cmd(CMD_WANT);
        repeat (10) send_cmd(CMD_REQ);
        repeat (4) run_round();
        // ticket saturation
        send_item(CMD_REQ, 16'hFFFF, 3'd0, 4'd9, 4'd9);
        send_cmd(CMD_WANT);
        send_cmd(CMD_WANT);
        send_item(CMD_REQ, 16'hFFFF, 3'd0, 4'd0, 4'd0);
        send_item(CMD_REQ, 16'hFFFF, 3'd1, 4'd0, 4'd0);
        send_cmd(CMD_OK);
        send_cmd(CMD_LEAVE);

        start <= 1'b0;
        for (int w = 0; w < 500 && sb.msgs_due.size() != 0; w++) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.msgs_due.size() != 0)
            $error("%0d expected result beats never arrived", sb.msgs_due.size());
        $display("%0d command beats driven under 7 register settings, %0d result beats checked",
                 sb.beats_in, sb.beats_out);
        $display("%0d entries, %0d deferred grants released, %0d requests dropped when full",
                 sb.enters, sb.released, sb.dropped);
        if (sb.errors == 0 && sb.msgs_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #1600000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/dmtn_pkg.sv
hdl/dmtn_cfg.sv
hdl/dmtn_ctrl.sv
hdl/dmtn_dp.sv
hdl/distributed_mutex_ticket_node.sv
test/distributed_mutex_ticket_node_tb.sv
